// ===== rtl/interrupt_and_keypad_registers_top_defines.svh =====
// Assertion macros for the interrupt and keypad register block.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef INTERRUPT_AND_KEYPAD_REGISTERS_TOP_DEFINES_SVH
`define INTERRUPT_AND_KEYPAD_REGISTERS_TOP_DEFINES_SVH

// checked outside reset
`define IKR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define IKR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/ikr_pkg.sv =====
// Types, codes, register map and helpers for the interrupt and keypad registers.
// No dependencies; used by the top level, ikr_keypad and ikr_regs.
`default_nettype none

package ikr_pkg;

   typedef enum logic [2:0] {
      OP_READ    = 3'd0,
      OP_WRITE   = 3'd1,
      OP_PRESS   = 3'd2,
      OP_RELEASE = 3'd3,
      OP_FLAG    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      REG_NONE,
      REG_KEY_STATUS,
      REG_KEY_CONTROL,
      REG_ENABLE,
      REG_FLAG,
      REG_MASTER
   } region_type;

   localparam int          KEY_COUNT    = 10;
   localparam logic [3:0]  KEY_LAST     = 4'd9;
   localparam logic [KEY_COUNT-1:0] KEY_ALL_UP = '1;
   localparam int          KC_IRQ_ENABLE = 14;
   localparam int          KC_IRQ_AND    = 15;
   localparam int          KEYPAD_FLAG   = 12;

   localparam logic [9:0]  OFF_KEY_STATUS  = 10'h130;
   localparam logic [9:0]  OFF_KEY_CONTROL = 10'h132;
   localparam logic [9:0]  OFF_ENABLE      = 10'h200;
   localparam logic [9:0]  OFF_FLAG        = 10'h202;
   localparam logic [9:0]  OFF_MASTER      = 10'h208;

   typedef struct packed {
      op_type      op;
      logic [9:0]  reg_offset;
      logic [7:0]  write_byte;
      logic [3:0]  key_number;
      logic [3:0]  flag_number;
      logic        flag_level;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic        irq_request;
      logic [15:0] pending_mask;
   } rsp_type;

   typedef struct packed {
      logic        press;
      logic        release_key;
      logic [3:0]  key_number;
   } key_evt_type;

   function automatic region_type decode_region(input logic [9:0] offset);
      region_type region;
      region = REG_NONE;
      if (offset[9:1] == OFF_KEY_STATUS[9:1])       region = REG_KEY_STATUS;
      else if (offset[9:1] == OFF_KEY_CONTROL[9:1]) region = REG_KEY_CONTROL;
      else if (offset[9:1] == OFF_ENABLE[9:1])      region = REG_ENABLE;
      else if (offset[9:1] == OFF_FLAG[9:1])        region = REG_FLAG;
      else if (offset[9:2] == OFF_MASTER[9:2])      region = REG_MASTER;
      return region;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ikr_if.sv =====
// Request and response channel interfaces (valid/ready plus payload fields).
// No dependencies.
`default_nettype none

interface ikr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [9:0]  reg_offset;
   logic [7:0]  write_byte;
   logic [3:0]  key_number;
   logic [3:0]  flag_number;
   logic        flag_level;

   modport source (output valid, op, reg_offset, write_byte, key_number,
                   flag_number, flag_level, input ready);
   modport sink   (input valid, op, reg_offset, write_byte, key_number,
                   flag_number, flag_level, output ready);
endinterface

interface ikr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_byte;
   logic        irq_request;
   logic [15:0] pending_mask;

   modport source (output valid, read_byte, irq_request, pending_mask, input ready);
   modport sink   (input valid, read_byte, irq_request, pending_mask, output ready);
endinterface

`default_nettype wire

// ===== rtl/interrupt_and_keypad_registers_top.sv =====
// Top level of the interrupt and keypad registers: input register, register
// update, result register. Depends on ikr_pkg, ikr_if, ikr_keypad, ikr_regs.
//
// One beat on req_bus is a bus byte read or write, a key press or release, or
// a flag set/clear; every beat yields exactly one beat on rsp_bus carrying the
// read byte (zero for non-reads), the pending mask (enable AND flags after the
// beat) and the interrupt request. The block takes one beat per clock unless
// the result stalls; a beat goes through the input register, the register
// update and the result register. A stalled result holds the pipeline only
// once both registers are full.
`default_nettype none
`include "interrupt_and_keypad_registers_top_defines.svh"

module interrupt_and_keypad_registers_top (
   input  logic      clock,
   input  logic      reset,
   ikr_req_if.sink   req_bus,
   ikr_rsp_if.source rsp_bus
);

   logic             in_valid_ff,  in_valid_in;
   ikr_pkg::req_type in_item_ff,   in_item_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ikr_pkg::rsp_type rsp_item_ff,  rsp_item_in;
   logic             out_free;
   logic             fire;
   logic             req_beat;
   ikr_pkg::req_type req_item;
   ikr_pkg::rsp_type result;
   ikr_pkg::key_evt_type key_evt;
   logic [15:0]      key_control;
   logic [ikr_pkg::KEY_COUNT-1:0] key_status;
   logic             raise_keypad;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign req_beat      = req_bus.valid && req_bus.ready;

   always_comb begin
      req_item.op          = ikr_pkg::op_type'(req_bus.op);
      req_item.reg_offset  = req_bus.reg_offset;
      req_item.write_byte  = req_bus.write_byte;
      req_item.key_number  = req_bus.key_number;
      req_item.flag_number = req_bus.flag_number;
      req_item.flag_level  = req_bus.flag_level;
   end

   always_comb begin
      in_valid_in  = req_beat ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      in_item_in   = req_beat ? req_item : in_item_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      rsp_item_in  = fire ? result : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      key_evt.press       = fire && (in_item_ff.op == ikr_pkg::OP_PRESS);
      key_evt.release_key = fire && (in_item_ff.op == ikr_pkg::OP_RELEASE);
      key_evt.key_number  = in_item_ff.key_number;
   end

   ikr_keypad u_keypad (
      .clock        (clock),
      .reset        (reset),
      .evt          (key_evt),
      .key_control  (key_control),
      .key_status   (key_status),
      .raise_keypad (raise_keypad)
   );

   ikr_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (in_item_ff),
      .key_status   (key_status),
      .raise_keypad (raise_keypad),
      .key_control  (key_control),
      .result       (result)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.read_byte    = rsp_item_ff.read_byte;
   assign rsp_bus.irq_request  = rsp_item_ff.irq_request;
   assign rsp_bus.pending_mask = rsp_item_ff.pending_mask;

   `IKR_ASSERT(a_fire_gives_rsp, fire |=> rsp_valid_ff, "processed beat produced no response")
   `IKR_ASSERT(a_no_overwrite, req_beat |-> (!in_valid_ff || fire), "input register overwritten")
   `IKR_ASSERT(a_irq_needs_pending, rsp_valid_ff && rsp_item_ff.irq_request |-> rsp_item_ff.pending_mask != '0, "irq without pending source")
   `IKR_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !in_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")

endmodule

`default_nettype wire

// ===== rtl/ikr_keypad.sv =====
// Key status register and keypad interrupt condition.
// Depends on ikr_pkg and the assertion macro header.
`default_nettype none
`include "interrupt_and_keypad_registers_top_defines.svh"

module ikr_keypad (
   input  logic                clock,
   input  logic                reset,
   input  ikr_pkg::key_evt_type evt,
   input  logic [15:0]         key_control,
   output logic [ikr_pkg::KEY_COUNT-1:0] key_status,
   output logic                raise_keypad
);

   logic [ikr_pkg::KEY_COUNT-1:0] key_status_ff;
   logic [ikr_pkg::KEY_COUNT-1:0] key_status_in;
   logic [ikr_pkg::KEY_COUNT-1:0] key_bit;
   logic                          key_valid;

   assign key_valid = (evt.key_number <= ikr_pkg::KEY_LAST);
   // shift past the top bit gives zero, so bad key numbers touch nothing
   assign key_bit   = ikr_pkg::KEY_COUNT'(1) << evt.key_number;

   always_comb begin
      key_status_in = key_status_ff;
      if (evt.press) begin
         key_status_in = key_status_ff & ~key_bit;
      end else if (evt.release_key) begin
         key_status_in = key_status_ff | key_bit;
      end
   end

   // AND mode checks the status after this press
   assign raise_keypad = evt.press && key_valid
                         && key_control[ikr_pkg::KC_IRQ_ENABLE]
                         && key_control[evt.key_number]
                         && (!key_control[ikr_pkg::KC_IRQ_AND]
                             || ((key_status_in
                                  & key_control[ikr_pkg::KEY_COUNT-1:0]) == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         key_status_ff <= ikr_pkg::KEY_ALL_UP;
      end else begin
         key_status_ff <= key_status_in;
      end
   end

   assign key_status = key_status_ff;

   `IKR_ASSERT_ALWAYS(a_status_reset, $past(reset) |-> key_status_ff == ikr_pkg::KEY_ALL_UP, "key status not all up after reset")
   `IKR_ASSERT(a_release_no_press, evt.release_key |=> (($past(key_status_ff) & ~key_status_ff) == '0), "release cleared a key bit")
   `IKR_ASSERT(a_press_no_release, evt.press |=> ((~$past(key_status_ff) & key_status_ff) == '0), "press set a key bit")
   `IKR_ASSERT(a_raise_enabled, raise_keypad |-> key_control[ikr_pkg::KC_IRQ_ENABLE], "keypad irq raised while disabled")

endmodule

`default_nettype wire

// ===== rtl/ikr_regs.sv =====
// Interrupt enable, flag, master enable and key control registers, read mux, result.
// Depends on ikr_pkg.
`default_nettype none

module ikr_regs (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  ikr_pkg::req_type    item,
   input  logic [ikr_pkg::KEY_COUNT-1:0] key_status,
   input  logic                raise_keypad,
   output logic [15:0]         key_control,
   output ikr_pkg::rsp_type    result
);

   logic [15:0] enable_ff,  enable_in;
   logic [15:0] flag_ff,    flag_in;
   logic [31:0] master_ff,  master_in;
   logic [15:0] control_ff, control_in;
   ikr_pkg::region_type region;
   logic [7:0]  read_data;
   logic [15:0] pending;
   logic        lane;

   assign region = ikr_pkg::decode_region(item.reg_offset);
   assign lane   = item.reg_offset[0];

   always_comb begin
      read_data = 8'd0;
      unique case (region)
         ikr_pkg::REG_KEY_STATUS:
            read_data = lane ? 8'(key_status[ikr_pkg::KEY_COUNT-1:8]) : key_status[7:0];
         ikr_pkg::REG_KEY_CONTROL: read_data = lane ? control_ff[15:8] : control_ff[7:0];
         ikr_pkg::REG_ENABLE:      read_data = lane ? enable_ff[15:8]  : enable_ff[7:0];
         ikr_pkg::REG_FLAG:        read_data = lane ? flag_ff[15:8]    : flag_ff[7:0];
         ikr_pkg::REG_MASTER:      read_data = master_ff[8*item.reg_offset[1:0] +: 8];
         default:                  read_data = 8'd0;
      endcase
   end

   always_comb begin
      enable_in  = enable_ff;
      flag_in    = flag_ff;
      master_in  = master_ff;
      control_in = control_ff;
      if (fire) begin
         case (item.op)
            ikr_pkg::OP_WRITE: begin
               unique case (region)
                  ikr_pkg::REG_KEY_CONTROL: control_in[8*lane +: 8] = item.write_byte;
                  ikr_pkg::REG_ENABLE:      enable_in[8*lane +: 8]  = item.write_byte;
                  ikr_pkg::REG_FLAG:
                     flag_in[8*lane +: 8] = flag_ff[8*lane +: 8] & ~item.write_byte;
                  ikr_pkg::REG_MASTER:
                     master_in[8*item.reg_offset[1:0] +: 8] = item.write_byte;
                  default: ;
               endcase
            end
            ikr_pkg::OP_PRESS: begin
               if (raise_keypad) begin
                  flag_in[ikr_pkg::KEYPAD_FLAG] = 1'b1;
               end
            end
            ikr_pkg::OP_FLAG: flag_in[item.flag_number] = item.flag_level;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= '0;
         flag_ff    <= '0;
         master_ff  <= '0;
         control_ff <= '0;
      end else begin
         enable_ff  <= enable_in;
         flag_ff    <= flag_in;
         master_ff  <= master_in;
         control_ff <= control_in;
      end
   end

   assign pending             = enable_in & flag_in;
   assign key_control         = control_ff;
   assign result.read_byte    = (item.op == ikr_pkg::OP_READ) ? read_data : 8'd0;
   assign result.pending_mask = pending;
   assign result.irq_request  = master_in[0] && (pending != '0);

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for interrupt_and_keypad_registers_top: directed and random bus, key and flag
// beats, each response checked against a register-level predictor in a scoreboard class.
// Depends on rtl/ikr_pkg.sv, rtl/ikr_if.sv and the block's RTL.

module tb_top;
   import ikr_pkg::*;

   localparam int         CLOCK_HALF      = 10;
   localparam int         RESET_CYCLES    = 10;
   localparam int         BEAT_COUNT      = 600;
   localparam int         HOLD_OFF_CYCLES = 64;
   localparam int         STALL_START     = 200;
   localparam int         DRAIN_POINT     = 400;
   localparam int         IDLE_LIMIT      = 1000;
   localparam int         TAIL_CYCLES     = 8;
   localparam logic [2:0] OP_SPARE_FIRST  = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST   = 3'd7;

   typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_type;

   class irq_scoreboard;
      logic [15:0]          enable_bits = '0;
      logic [15:0]          flag_bits   = '0;
      logic [31:0]          master_bits = '0;
      logic [KEY_COUNT-1:0] keys_up     = KEY_ALL_UP;
      logic [15:0]          key_ctl     = '0;
      rsp_type              status_q[$];
      int                   mismatches  = 0;

      task report(input string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      function rsp_type apply_beat(input req_type r);
         rsp_type              s;
         logic [15:0]          key_word;
         logic [15:0]          lane;
         logic [KEY_COUNT-1:0] sel;
         s = '0;
         key_word = {{(16-KEY_COUNT){1'b0}}, keys_up};
         lane = r.reg_offset[0] ? {r.write_byte, 8'h00} : {8'h00, r.write_byte};
         case (r.op)
            OP_READ: begin
               if (r.reg_offset[9:1] == OFF_KEY_STATUS[9:1])
                  s.read_byte = key_word[r.reg_offset[0]*8 +: 8];
               else if (r.reg_offset[9:1] == OFF_KEY_CONTROL[9:1])
                  s.read_byte = key_ctl[r.reg_offset[0]*8 +: 8];
               else if (r.reg_offset[9:1] == OFF_ENABLE[9:1])
                  s.read_byte = enable_bits[r.reg_offset[0]*8 +: 8];
               else if (r.reg_offset[9:1] == OFF_FLAG[9:1])
                  s.read_byte = flag_bits[r.reg_offset[0]*8 +: 8];
               else if (r.reg_offset[9:2] == OFF_MASTER[9:2])
                  s.read_byte = master_bits[r.reg_offset[1:0]*8 +: 8];
            end
            OP_WRITE: begin
               if (r.reg_offset[9:1] == OFF_KEY_CONTROL[9:1])
                  key_ctl[r.reg_offset[0]*8 +: 8] = r.write_byte;
               else if (r.reg_offset[9:1] == OFF_ENABLE[9:1])
                  enable_bits[r.reg_offset[0]*8 +: 8] = r.write_byte;
               else if (r.reg_offset[9:1] == OFF_FLAG[9:1])
                  flag_bits = flag_bits & ~lane;
               else if (r.reg_offset[9:2] == OFF_MASTER[9:2])
                  master_bits[r.reg_offset[1:0]*8 +: 8] = r.write_byte;
            end
            OP_PRESS: begin
               if (r.key_number <= KEY_LAST) begin
                  keys_up[r.key_number] = 1'b0;
                  sel = key_ctl[KEY_COUNT-1:0];
                  if (key_ctl[KC_IRQ_ENABLE] && key_ctl[r.key_number]) begin
                     if (!key_ctl[KC_IRQ_AND] || (keys_up & sel) == '0)
                        flag_bits[KEYPAD_FLAG] = 1'b1;
                  end
               end
            end
            OP_RELEASE: begin
               if (r.key_number <= KEY_LAST)
                  keys_up[r.key_number] = 1'b1;
            end
            OP_FLAG: flag_bits[r.flag_number] = r.flag_level;
            default: ;
         endcase
         s.pending_mask = enable_bits & flag_bits;
         s.irq_request  = master_bits[0] && (s.pending_mask != '0);
         return s;
      endfunction

      function void note_request(input req_type r);
         status_q = {status_q, apply_beat(r)};
      endfunction

      task check_response(input rsp_type got);
         rsp_type want;
         if (status_q.size() == 0) begin
            report("response beat with no request outstanding");
         end else begin
            want = status_q.pop_front();
            if (got.read_byte !== want.read_byte)
               report($sformatf("read_byte got %02h want %02h", got.read_byte, want.read_byte));
            if (got.irq_request !== want.irq_request)
               report($sformatf("irq_request got %b want %b", got.irq_request,
                                want.irq_request));
            if (got.pending_mask !== want.pending_mask)
               report($sformatf("pending_mask got %04h want %04h", got.pending_mask,
                                want.pending_mask));
         end
      endtask

      function int waiting();
         return status_q.size();
      endfunction
   endclass

   logic          clock;
   logic          reset;
   ikr_req_if     req_bus();
   ikr_rsp_if     rsp_bus();
   irq_scoreboard sb = new;
   bit            rsp_hold_req = 1'b0;
   int            beats_sent   = 0;
   int            burst_left   = 1;
   int            idle_cycles  = 0;

   interrupt_and_keypad_registers_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic req_type noise_beat();
      req_type r;
      r.op          = op_type'(3'($urandom));
      r.reg_offset  = 10'($urandom);
      r.write_byte  = 8'($urandom);
      r.key_number  = 4'($urandom);
      r.flag_number = 4'($urandom);
      r.flag_level  = 1'($urandom);
      return r;
   endfunction

   function automatic req_type bus_read_beat(input logic [9:0] off);
      req_type r;
      r = noise_beat();
      r.op = OP_READ;
      r.reg_offset = off;
      return r;
   endfunction

   function automatic req_type bus_write_beat(input logic [9:0] off, input logic [7:0] b);
      req_type r;
      r = noise_beat();
      r.op = OP_WRITE;
      r.reg_offset = off;
      r.write_byte = b;
      return r;
   endfunction

   function automatic req_type key_beat(input op_type op, input logic [3:0] k);
      req_type r;
      r = noise_beat();
      r.op = op;
      r.key_number = k;
      return r;
   endfunction

   function automatic req_type flag_beat(input logic [3:0] n, input logic lvl);
      req_type r;
      r = noise_beat();
      r.op = OP_FLAG;
      r.flag_number = n;
      r.flag_level = lvl;
      return r;
   endfunction

   function automatic req_type spare_beat();
      req_type r;
      r = noise_beat();
      r.op = op_type'(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
      return r;
   endfunction

   function automatic logic [3:0] pick_key();
      if ($urandom_range(0, 9) == 0)
         return 4'($urandom_range(KEY_LAST + 1, 15));
      return 4'($urandom_range(0, KEY_LAST));
   endfunction

   function automatic logic [9:0] mapped_offset();
      case ($urandom_range(0, 4))
         0:       return OFF_KEY_STATUS + 10'($urandom_range(0, 1));
         1:       return OFF_KEY_CONTROL + 10'($urandom_range(0, 1));
         2:       return OFF_ENABLE + 10'($urandom_range(0, 1));
         3:       return OFF_FLAG + 10'($urandom_range(0, 1));
         default: return OFF_MASTER + 10'($urandom_range(0, 3));
      endcase
   endfunction

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   task automatic send_beat(input req_type r);
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.op          <= r.op;
      req_bus.reg_offset  <= r.reg_offset;
      req_bus.write_byte  <= r.write_byte;
      req_bus.key_number  <= r.key_number;
      req_bus.flag_number <= r.flag_number;
      req_bus.flag_level  <= r.flag_level;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      beats_sent++;
      burst_left--;
      if (burst_left == 0) begin
         idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic wait_drained();
      while (sb.waiting() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : monitor
      req_type seen_req;
      rsp_type seen_rsp;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen_req.op          = op_type'(req_bus.op);
            seen_req.reg_offset  = req_bus.reg_offset;
            seen_req.write_byte  = req_bus.write_byte;
            seen_req.key_number  = req_bus.key_number;
            seen_req.flag_number = req_bus.flag_number;
            seen_req.flag_level  = req_bus.flag_level;
            sb.note_request(seen_req);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.read_byte    = rsp_bus.read_byte;
            seen_rsp.irq_request  = rsp_bus.irq_request;
            seen_rsp.pending_mask = rsp_bus.pending_mask;
            sb.check_response(seen_rsp);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stall pattern; long hold-off on request
   initial begin : rsp_pacing
      rx_mode_type mode;
      int          span;
      rsp_bus.ready = 1'b0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 2));
         span = $urandom_range(4, 40);
         for (int n = 0; n < span; n++) begin
            @(negedge clock);
            if (rsp_hold_req) begin
               rsp_hold_req = 1'b0;
               rsp_bus.ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(negedge clock);
            end else begin
               case (mode)
                  RX_OPEN:   rsp_bus.ready <= 1'b1;
                  RX_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
                  default:   rsp_bus.ready <= (n % 3 != 2);
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      logic [KEY_COUNT-1:0] sel;
      logic [15:0]          ctl;
      logic [15:0]          kp_clear;
      int                   pick;
      bit                   stall_done;
      bit                   drain_done;
      stall_done = 1'b0;
      drain_done = 1'b0;
      kp_clear = 16'd1 << KEYPAD_FLAG;
      reset = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_READ;
      req_bus.reg_offset  = '0;
      req_bus.write_byte  = '0;
      req_bus.key_number  = '0;
      req_bus.flag_number = '0;
      req_bus.flag_level  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_beat(bus_read_beat(OFF_KEY_STATUS));
      send_beat(bus_read_beat(OFF_KEY_STATUS + 10'd1));
      send_beat(bus_write_beat(OFF_ENABLE, 8'hFF));
      send_beat(bus_write_beat(OFF_ENABLE + 10'd1, 8'hFF));
      send_beat(bus_write_beat(OFF_MASTER, 8'h01));
      send_beat(bus_write_beat(OFF_MASTER + 10'd3, 8'hFF));
      send_beat(flag_beat(4'd15, 1'b1));
      send_beat(flag_beat(4'd0, 1'b1));
      send_beat(bus_write_beat(OFF_FLAG + 10'd1, 8'h80));
      send_beat(flag_beat(4'd0, 1'b0));
      // AND mode over keys 0 and 1
      send_beat(bus_write_beat(OFF_KEY_CONTROL, 8'h03));
      send_beat(bus_write_beat(OFF_KEY_CONTROL + 10'd1, 8'hC0));
      send_beat(key_beat(OP_PRESS, 4'd0));
      send_beat(key_beat(OP_PRESS, 4'd1));
      send_beat(bus_read_beat(OFF_KEY_STATUS));
      send_beat(bus_write_beat(OFF_FLAG + 10'd1, kp_clear[15:8]));
      // OR mode, keys 0, 1 and 9
      send_beat(bus_write_beat(OFF_KEY_CONTROL + 10'd1, 8'h42));
      send_beat(key_beat(OP_PRESS, 4'd9));
      send_beat(key_beat(OP_PRESS, 4'd12));
      send_beat(key_beat(OP_RELEASE, 4'd9));
      send_beat(key_beat(OP_RELEASE, 4'd15));
      send_beat(bus_write_beat(OFF_KEY_STATUS, 8'h00));
      send_beat(bus_write_beat(10'h3FF, 8'hFF));
      send_beat(bus_read_beat(10'h3FF));
      send_beat(bus_read_beat(OFF_MASTER + 10'd3));
      send_beat(spare_beat());
      send_beat(bus_read_beat(OFF_FLAG));
      idle_sender(1);
      wait_drained();

      while (beats_sent < BEAT_COUNT) begin
         if (beats_sent >= STALL_START && !stall_done) begin
            rsp_hold_req = 1'b1;
            stall_done = 1'b1;
         end
         if (beats_sent >= DRAIN_POINT && !drain_done) begin
            idle_sender(1);
            wait_drained();
            drain_done = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // program a small key selection, then press it
            sel = '0;
            repeat ($urandom_range(1, 3)) sel[$urandom_range(0, KEY_COUNT - 1)] = 1'b1;
            ctl = 16'($urandom);
            ctl[KEY_COUNT-1:0] = sel;
            ctl[KC_IRQ_ENABLE] = 1'b1;
            send_beat(bus_write_beat(OFF_KEY_CONTROL, ctl[7:0]));
            send_beat(bus_write_beat(OFF_KEY_CONTROL + 10'd1, ctl[15:8]));
            for (int i = 0; i < KEY_COUNT; i++)
               if (sel[i]) send_beat(key_beat(OP_PRESS, 4'(i)));
            send_beat(bus_read_beat(OFF_FLAG + 10'd1));
            if ($urandom_range(0, 1))
               send_beat(bus_write_beat(OFF_FLAG + 10'd1, kp_clear[15:8]));
            for (int i = 0; i < KEY_COUNT; i++)
               if (sel[i] && $urandom_range(0, 1)) send_beat(key_beat(OP_RELEASE, 4'(i)));
         end else if (pick < 38) begin
            send_beat(bus_read_beat(mapped_offset()));
         end else if (pick < 43) begin
            send_beat(bus_read_beat(10'($urandom)));
         end else if (pick < 63) begin
            send_beat(bus_write_beat(mapped_offset(), 8'($urandom)));
         end else if (pick < 66) begin
            send_beat(bus_write_beat(10'($urandom), 8'($urandom)));
         end else if (pick < 79) begin
            send_beat(key_beat(OP_PRESS, pick_key()));
         end else if (pick < 88) begin
            send_beat(key_beat(OP_RELEASE, pick_key()));
         end else if (pick < 98) begin
            send_beat(flag_beat(4'($urandom), 1'($urandom)));
         end else begin
            send_beat(spare_beat());
         end
      end

      idle_sender(1);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
